// File: design/phd_pkg.sv
// ----------------------------------------------------------------------------
// phd_pkg: shared types and constants for the piezo hit peak detector
// Holds default parameter values, field widths, register indexes, the per
// channel phase codes and the command and status words of the controller.
// ----------------------------------------------------------------------------
package phd_pkg;

   // Defaults for the top level parameters.
   localparam int DEF_WINDOW_LEN  = 50;
   localparam int DEF_SAMPLE_BITS = 10;

   // Fixed field widths.
   localparam int NUM_CH    = 3;
   localparam int CH_W      = 2;
   localparam int CFG_W     = 10;
   localparam int PEAK_W    = 10;
   localparam int CSR_IDX_W = 1;

   // Highest valid channel number.
   localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CH - 1);

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_RISE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL = 1'b1;

   // Threshold values after reset.
   localparam logic [CFG_W-1:0] RISE_RESET = 10'd60;
   localparam logic [CFG_W-1:0] FALL_RESET = 10'd20;

   // Per channel detector phase.
   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_RISING  = 2'd1,
      PH_FALLING = 2'd2
   } phase_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the accepted input word
      logic write;     // write the sample into the channel window
      logic read;      // read one window entry at the scan index
      logic first;     // this read starts a new min/max scan
      logic commit;    // update detector state and load the result word
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic ch_invalid; // captured channel number has no sensor
      logic out_free;   // result register can take a word this cycle
   } status_type;

endpackage

// File: design/piezo_hit_peak_detector.sv
// ----------------------------------------------------------------------------
// piezo_hit_peak_detector: three channel piezo hit detector
// Rolling window range per channel, idle/rising/falling hit detection,
// loudest channel report and hit indicator.
// ----------------------------------------------------------------------------
// Each accepted word carries one converter sample and the channel it belongs
// to; it returns exactly one result word. The sample goes into that channel's
// window of WINDOW_LEN entries, and the window's max minus min is the range
// that drives the channel's idle, rising and falling phases. From acceptance
// until the block takes the next word, it steps through capture, a write of
// the window memory, a walk of all WINDOW_LEN window entries for min and max
// by the single read port of that memory, a drain step for the last read to
// land and a commit of the result. A word for channel three has no sensor;
// it skips the window write and scan, goes straight to the commit step and
// reports only the indicator level. The result sits in an output register,
// so the block starts on the next word while the previous result is still
// stalled; it only waits at the commit step if that register is still full.
// The windows read as zero after reset without any clearing pass, because
// each channel tracks how far its window has been filled. The thresholds may
// be written only while the block has no word in flight.
// ----------------------------------------------------------------------------
module piezo_hit_peak_detector #(
   parameter int WINDOW_LEN  = phd_pkg::DEF_WINDOW_LEN,
   parameter int SAMPLE_BITS = phd_pkg::DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [phd_pkg::CH_W-1:0]      req_channel,
   input  logic [SAMPLE_BITS-1:0]        req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic                          rsp_led_on,
   output logic [phd_pkg::PEAK_W-1:0]    rsp_peak_bow,
   output logic [phd_pkg::PEAK_W-1:0]    rsp_peak_bell,
   output logic [phd_pkg::PEAK_W-1:0]    rsp_peak_edge,
   output logic [phd_pkg::CH_W-1:0]      rsp_loudest,
   input  logic                          csr_write,
   input  logic [phd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [phd_pkg::CFG_W-1:0]     csr_data
);
   import phd_pkg::*;

   cmd_type                      cmd;
   status_type                   status;
   logic [$clog2(WINDOW_LEN)-1:0] rd_idx;

   // The controller only sequences; all state of the detector lives in the
   // datapath.
   phd_ctrl #(
      .WINDOW_LEN(WINDOW_LEN)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd),
      .rd_idx   (rd_idx)
   );

   phd_datapath #(
      .WINDOW_LEN (WINDOW_LEN),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .rd_idx       (rd_idx),
      .status       (status),
      .req_channel  (req_channel),
      .req_sample   (req_sample),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_hit      (rsp_hit),
      .rsp_led_on   (rsp_led_on),
      .rsp_peak_bow (rsp_peak_bow),
      .rsp_peak_bell(rsp_peak_bell),
      .rsp_peak_edge(rsp_peak_edge),
      .rsp_loudest  (rsp_loudest)
   );

   // A hit always leaves the indicator on.
   a_hit_sets_led: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> rsp_led_on)
      else $error("hit reported with indicator off");

   // Without a hit the peak fields and the loudest channel are all zero.
   a_quiet_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_peak_bow == '0 && rsp_peak_bell == '0 &&
                                   rsp_peak_edge == '0 && rsp_loudest == '0))
      else $error("peak fields set without a hit");

   // The loudest channel is always a real sensor.
   a_loudest_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_loudest <= CH_LAST))
      else $error("loudest names a channel without a sensor");

   // One word at a time: after an accepted word the input stalls.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second word accepted while one is in flight");

endmodule

// File: design/phd_ram.sv
// ----------------------------------------------------------------------------
// phd_ram: generic simple dual port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module phd_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 150
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/phd_ctrl.sv
// ----------------------------------------------------------------------------
// phd_ctrl: sequencing controller of the piezo hit peak detector
// Accepts one word; for a channel with a sensor it has it written into its
// window and steps the window scan; commits the result once the result register is free.
// ----------------------------------------------------------------------------
module phd_ctrl #(
   parameter int WINDOW_LEN = 50
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  phd_pkg::status_type           status,
   output phd_pkg::cmd_type              cmd,
   output logic [$clog2(WINDOW_LEN)-1:0] rd_idx
);
   import phd_pkg::*;

   localparam int IDX_W = $clog2(WINDOW_LEN);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_LEN - 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_WRITE  = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_WRITE;
            end
         end
         ST_WRITE: begin
            idx_in = '0;
            if (status.ch_invalid) begin
               state_in = ST_FINISH;
            end else begin
               cmd.write = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.read  = 1'b1;
            cmd.first = (idx_ff == '0);
            if (idx_ff == IDX_LAST) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // The last entry's read data lands in this cycle.
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rd_idx    = idx_ff;

endmodule

// File: design/phd_datapath.sv
// ----------------------------------------------------------------------------
// phd_datapath: window storage, range scan and hit logic
// Holds the sample windows, per channel detector state, the thresholds and
// the result register.
// ----------------------------------------------------------------------------
module phd_datapath #(
   parameter int WINDOW_LEN  = 50,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  phd_pkg::cmd_type                   cmd,
   input  logic [$clog2(WINDOW_LEN)-1:0]      rd_idx,
   output phd_pkg::status_type                status,
   input  logic [phd_pkg::CH_W-1:0]           req_channel,
   input  logic [SAMPLE_BITS-1:0]             req_sample,
   input  logic                               csr_write,
   input  logic [phd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [phd_pkg::CFG_W-1:0]          csr_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_hit,
   output logic                               rsp_led_on,
   output logic [phd_pkg::PEAK_W-1:0]         rsp_peak_bow,
   output logic [phd_pkg::PEAK_W-1:0]         rsp_peak_bell,
   output logic [phd_pkg::PEAK_W-1:0]         rsp_peak_edge,
   output logic [phd_pkg::CH_W-1:0]           rsp_loudest
);
   import phd_pkg::*;

   localparam int IDX_W  = $clog2(WINDOW_LEN);
   localparam int DEPTH  = NUM_CH * WINDOW_LEN;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CMP_W  = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_LEN - 1);

   logic [CFG_W-1:0]       rise_ff, fall_ff;
   logic [CH_W-1:0]        ch_ff;
   logic [SAMPLE_BITS-1:0] smp_ff;
   logic [IDX_W-1:0]       slot_ff [NUM_CH];
   logic                   full_ff [NUM_CH];
   logic [SAMPLE_BITS-1:0] last_ff [NUM_CH];
   logic [SAMPLE_BITS-1:0] last_in [NUM_CH];
   phase_type              phase_ff [NUM_CH];
   phase_type              phase_in [NUM_CH];
   logic                   ind_ff, ind_in;
   logic                   rd_vld_ff, rd_first_ff;
   logic [IDX_W-1:0]       rd_idx_ff;
   logic [SAMPLE_BITS-1:0] min_ff, max_ff;

   logic                   rsp_valid_ff, rsp_hit_ff, rsp_led_ff;
   logic [PEAK_W-1:0]      rsp_peak_ff [NUM_CH];
   logic [PEAK_W-1:0]      peak_in [NUM_CH];
   logic [CH_W-1:0]        rsp_loud_ff, loud_in;
   logic                   hit_in;

   logic [ADDR_W-1:0]      base_addr, wr_addr, rd_addr;
   logic [SAMPLE_BITS-1:0] rd_data, entry_val, range_val;
   logic                   ch_valid;

   assign ch_valid  = (ch_ff <= CH_LAST);
   assign base_addr = ADDR_W'(ch_ff) * ADDR_W'(WINDOW_LEN);
   assign wr_addr   = base_addr + ADDR_W'(slot_ff[ch_ff]);
   assign rd_addr   = base_addr + ADDR_W'(rd_idx);

   phd_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(DEPTH)
   ) u_window (
      .clock  (clock),
      .wr_en  (cmd.write),
      .wr_addr(wr_addr),
      .wr_data(smp_ff),
      .rd_en  (cmd.read),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Entries not yet written since reset read as zero.
   assign entry_val = (full_ff[ch_ff] || (rd_idx_ff < slot_ff[ch_ff])) ? rd_data : '0;
   assign range_val = max_ff - min_ff;

   always_comb begin
      logic [SAMPLE_BITS-1:0] best;
      logic [CMP_W-1:0]       range_c;
      for (int i = 0; i < NUM_CH; i++) begin
         last_in[i]  = last_ff[i];
         phase_in[i] = phase_ff[i];
         peak_in[i]  = '0;
      end
      ind_in  = ind_ff;
      hit_in  = 1'b0;
      loud_in = '0;
      best    = '0;
      range_c = CMP_W'(range_val);
      if (ch_valid) begin
         case (phase_ff[ch_ff])
            PH_IDLE: begin
               if (range_c > CMP_W'(rise_ff)) begin
                  phase_in[ch_ff] = PH_RISING;
               end
            end
            PH_RISING: begin
               if (range_val < last_ff[ch_ff]) begin
                  hit_in = 1'b1;
                  ind_in = 1'b1;
                  for (int i = 0; i < NUM_CH; i++) begin
                     peak_in[i]  = PEAK_W'(CMP_W'(last_ff[i]));
                     phase_in[i] = PH_FALLING;
                     if (last_ff[i] > best) begin
                        best    = last_ff[i];
                        loud_in = CH_W'(i);
                     end
                  end
               end
            end
            default: begin
               if (range_c < CMP_W'(fall_ff)) begin
                  phase_in[ch_ff] = PH_IDLE;
                  ind_in          = 1'b0;
               end
            end
         endcase
         last_in[ch_ff] = range_val;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rise_ff <= RISE_RESET;
         fall_ff <= FALL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_RISE: rise_ff <= csr_data;
            CSR_FALL: fall_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Detector state.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CH; i++) begin
            slot_ff[i]  <= '0;
            full_ff[i]  <= 1'b0;
            last_ff[i]  <= '0;
            phase_ff[i] <= PH_FALLING;
         end
         ind_ff       <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.read;
         if (cmd.write) begin
            if (slot_ff[ch_ff] == IDX_LAST) begin
               slot_ff[ch_ff] <= '0;
               full_ff[ch_ff] <= 1'b1;
            end else begin
               slot_ff[ch_ff] <= slot_ff[ch_ff] + 1'b1;
            end
         end
         if (cmd.commit) begin
            for (int i = 0; i < NUM_CH; i++) begin
               last_ff[i]  <= last_in[i];
               phase_ff[i] <= phase_in[i];
            end
            ind_ff       <= ind_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ch_ff  <= req_channel;
         smp_ff <= req_sample;
      end
      rd_first_ff <= cmd.first;
      rd_idx_ff   <= rd_idx;
      if (rd_vld_ff) begin
         if (rd_first_ff) begin
            min_ff <= entry_val;
            max_ff <= entry_val;
         end else begin
            if (entry_val < min_ff) begin
               min_ff <= entry_val;
            end
            if (entry_val > max_ff) begin
               max_ff <= entry_val;
            end
         end
      end
      if (cmd.commit) begin
         rsp_hit_ff  <= hit_in;
         rsp_led_ff  <= ind_in;
         rsp_loud_ff <= loud_in;
         for (int i = 0; i < NUM_CH; i++) begin
            rsp_peak_ff[i] <= peak_in[i];
         end
      end
   end

   assign status.ch_invalid = !ch_valid;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_led_on    = rsp_led_ff;
   assign rsp_peak_bow  = rsp_peak_ff[0];
   assign rsp_peak_bell = rsp_peak_ff[1];
   assign rsp_peak_edge = rsp_peak_ff[2];
   assign rsp_loudest   = rsp_loud_ff;

endmodule
